### rtl/sit_pkg.sv
package sit_pkg;

    // Field widths
    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_W         = PARAM_FRAC_BITS + 2;

    // Internal arithmetic widths
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W;

    // Divider layout: fraction bits resolved per stage, and stage count
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (PARAM_FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Inputs, differences, products, crosses, magnitudes, divider init,
    // divider stages, output
    localparam int LATENCY = 7 + DIV_STAGES;

    // Quotient constants
    localparam logic [PARAM_W-1:0] Q_MAXPOS  = PARAM_W'((1 << (PARAM_FRAC_BITS + 1)) - 1);
    localparam logic [PARAM_W-1:0] Q_SAT_NEG = PARAM_W'(1 << (PARAM_FRAC_BITS + 1));
    localparam logic [PARAM_W-1:0] Q_MINUS1  = PARAM_W'(-(1 << PARAM_FRAC_BITS));

    // One divider lane in flight
    typedef struct packed {
        logic [MAG_W-1:0]   rem;
        logic [MAG_W-1:0]   dvs;
        logic [PARAM_W-1:0] quo;
        logic               neg;
        logic               sat;
    } sit_lane_t;

    // Flags that travel beside the divider lanes
    typedef struct packed {
        logic vld;
        logic crs;
        logic par;
    } sit_flags_t;

    // One restoring step: shift remainder, subtract divisor if it fits
    function automatic sit_lane_t div_step(sit_lane_t s);
        logic [MAG_W:0] sh;
        logic [MAG_W:0] dif;
        sit_lane_t      o;
        o   = s;
        sh  = {s.rem, 1'b0};
        dif = sh - {1'b0, s.dvs};
        if (sh >= {1'b0, s.dvs})
        begin
            o.rem = dif[MAG_W-1:0];
            o.quo = {s.quo[PARAM_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[MAG_W-1:0];
            o.quo = {s.quo[PARAM_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### rtl/segment_intersection_test.sv
// Segment intersection test. Pulse start with both segments on the input
// ports while busy is low; one pair is taken every clock cycle. Each pair
// gives exactly one result, marked by a one-cycle done strobe, after the
// stages that LATENCY in sit_pkg sums up:
// five stages of input capture, differences, products, cross products and
// magnitudes, one divider setup stage, one stage per two quotient bits of
// the restoring divider (8 stages for 16 fraction bits), and the output
// register. Results cannot be held off and must be taken in the cycle they
// appear. busy is high only in the first cycle after reset. t and u are
// truncated toward zero and saturated to [-2, 2); crosses is decided exactly
// from the cross products. A zero denominator gives parallel = 1,
// crosses = 0, t = u = -1.
module segment_intersection_test (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  a_start_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  a_start_y,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  a_end_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  a_end_y,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  b_start_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  b_start_y,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  b_end_x,
    input  logic signed [sit_pkg::COORD_BITS-1:0]  b_end_y,
    output logic                                   done,
    output logic                                   crosses,
    output logic                                   parallel,
    output logic signed [sit_pkg::PARAM_W-1:0]     param_first,
    output logic signed [sit_pkg::PARAM_W-1:0]     param_second
);
    import sit_pkg::*;

    // ---------------- control ----------------
    logic busy_reg;
    logic accept;

    // Not ready for the first cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // Valid bits of the front stages
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg, vld_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= accept;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
        end
    end

    // ---------------- stage A: input capture ----------------
    logic signed [COORD_BITS-1:0] asx_reg, asy_reg, aex_reg, aey_reg;
    logic signed [COORD_BITS-1:0] bsx_reg, bsy_reg, bex_reg, bey_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            asx_reg <= a_start_x;
            asy_reg <= a_start_y;
            aex_reg <= a_end_x;
            aey_reg <= a_end_y;
            bsx_reg <= b_start_x;
            bsy_reg <= b_start_y;
            bex_reg <= b_end_x;
            bey_reg <= b_end_y;
        end
    end

    // ---------------- stage B: edge differences ----------------
    logic signed [DIFF_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg, dsx_reg, dsy_reg;

    always_ff @(posedge clk)
    begin
        dax_reg <= DIFF_W'(asx_reg) - DIFF_W'(aex_reg);
        day_reg <= DIFF_W'(asy_reg) - DIFF_W'(aey_reg);
        dbx_reg <= DIFF_W'(bsx_reg) - DIFF_W'(bex_reg);
        dby_reg <= DIFF_W'(bsy_reg) - DIFF_W'(bey_reg);
        dsx_reg <= DIFF_W'(asx_reg) - DIFF_W'(bsx_reg);
        dsy_reg <= DIFF_W'(asy_reg) - DIFF_W'(bsy_reg);
    end

    // ---------------- stage C: six products ----------------
    logic signed [PROD_W-1:0] prod_reg [6];

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= PROD_W'(dax_reg) * PROD_W'(dby_reg);
        prod_reg[1] <= PROD_W'(day_reg) * PROD_W'(dbx_reg);
        prod_reg[2] <= PROD_W'(dsx_reg) * PROD_W'(dby_reg);
        prod_reg[3] <= PROD_W'(dsy_reg) * PROD_W'(dbx_reg);
        prod_reg[4] <= PROD_W'(day_reg) * PROD_W'(dsx_reg);
        prod_reg[5] <= PROD_W'(dax_reg) * PROD_W'(dsy_reg);
    end

    // ---------------- stage D: denominator and numerators ----------------
    logic signed [CROSS_W-1:0] den_reg, nt_reg, nu_reg;

    always_ff @(posedge clk)
    begin
        den_reg <= CROSS_W'(prod_reg[0]) - CROSS_W'(prod_reg[1]);
        nt_reg  <= CROSS_W'(prod_reg[2]) - CROSS_W'(prod_reg[3]);
        nu_reg  <= CROSS_W'(prod_reg[4]) - CROSS_W'(prod_reg[5]);
    end

    // ---------------- stage E: signs, magnitudes, exact range test ----------------
    logic             unit_t, unit_u;
    logic [MAG_W-1:0] mag_t_reg, mag_u_reg, mag_d_reg;
    logic             neg_t_reg, neg_u_reg, crs_e_reg, par_e_reg;

    always_comb
    begin
        if (den_reg > 0)
        begin
            unit_t = (nt_reg >= 0) && (nt_reg <= den_reg);
            unit_u = (nu_reg >= 0) && (nu_reg <= den_reg);
        end
        else
        begin
            unit_t = (nt_reg <= 0) && (nt_reg >= den_reg);
            unit_u = (nu_reg <= 0) && (nu_reg >= den_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        mag_t_reg <= nt_reg[CROSS_W-1]  ? MAG_W'(-nt_reg)  : MAG_W'(nt_reg);
        mag_u_reg <= nu_reg[CROSS_W-1]  ? MAG_W'(-nu_reg)  : MAG_W'(nu_reg);
        mag_d_reg <= den_reg[CROSS_W-1] ? MAG_W'(-den_reg) : MAG_W'(den_reg);
        neg_t_reg <= nt_reg[CROSS_W-1] != den_reg[CROSS_W-1];
        neg_u_reg <= nu_reg[CROSS_W-1] != den_reg[CROSS_W-1];
        par_e_reg <= (den_reg == '0);
        crs_e_reg <= (den_reg != '0) && unit_t && unit_u;
    end

    // ---------------- divider: setup stage and bit stages ----------------
    // Index 0 is the setup stage, index k+1 follows bit stage k.
    sit_lane_t  lt_reg  [DIV_STAGES+1];
    sit_lane_t  lu_reg  [DIV_STAGES+1];
    sit_flags_t flg_reg [DIV_STAGES+1];

    // Saturation check and integer bit
    function automatic sit_lane_t div_init(logic [MAG_W-1:0] n, logic [MAG_W-1:0] d, logic neg);
        sit_lane_t o;
        logic      ge;
        ge    = (n >= d);
        o.sat = ({1'b0, n} >= {d, 1'b0});
        o.neg = neg;
        o.dvs = d;
        o.rem = ge ? (n - d) : n;
        o.quo = {{(PARAM_W-1){1'b0}}, ge};
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        lt_reg[0] <= div_init(mag_t_reg, mag_d_reg, neg_t_reg);
        lu_reg[0] <= div_init(mag_u_reg, mag_d_reg, neg_u_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flg_reg[0] <= '0;
        else
            flg_reg[0] <= {vld_e_reg, crs_e_reg, par_e_reg};
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_div
            sit_lane_t lt_next, lu_next;

            // Up to STEPS_PER_STAGE quotient bits per stage
            always_comb
            begin
                lt_next = lt_reg[k];
                lu_next = lu_reg[k];
                for (int j = 0; j < STEPS_PER_STAGE; j++)
                begin
                    if (k * STEPS_PER_STAGE + j < PARAM_FRAC_BITS)
                    begin
                        lt_next = div_step(lt_next);
                        lu_next = div_step(lu_next);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                lt_reg[k+1] <= lt_next;
                lu_reg[k+1] <= lu_next;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    flg_reg[k+1] <= '0;
                else
                    flg_reg[k+1] <= flg_reg[k];
            end
        end
    endgenerate

    // ---------------- output stage: saturate, sign, parallel case ----------------
    function automatic logic [PARAM_W-1:0] finish(sit_lane_t s, logic par);
        logic [PARAM_W-1:0] q;
        if (s.sat)
            q = s.neg ? Q_SAT_NEG : Q_MAXPOS;
        else
            q = s.quo;
        if (par)
            return Q_MINUS1;
        return s.neg ? (~q + 1'b1) : q;
    endfunction

    logic                done_reg, crosses_reg, parallel_reg;
    logic [PARAM_W-1:0]  pf_reg, ps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= flg_reg[DIV_STAGES].vld;
    end

    always_ff @(posedge clk)
    begin
        crosses_reg  <= flg_reg[DIV_STAGES].crs;
        parallel_reg <= flg_reg[DIV_STAGES].par;
        pf_reg       <= finish(lt_reg[DIV_STAGES], flg_reg[DIV_STAGES].par);
        ps_reg       <= finish(lu_reg[DIV_STAGES], flg_reg[DIV_STAGES].par);
    end

    assign done         = done_reg;
    assign crosses      = crosses_reg;
    assign parallel     = parallel_reg;
    assign param_first  = pf_reg;
    assign param_second = ps_reg;

`ifndef SYNTH
    // Every accepted beat produces a done strobe, timed by LATENCY
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result strobe missing after accepted beat");

    // Parallel segments never cross and give both parameters as -1
    a_par_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (done && parallel) |-> (!crosses && param_first == Q_MINUS1
                                && param_second == Q_MINUS1))
        else $error("parallel result with crossing or wrong parameters");

    // A crossing implies both parameters are nonnegative
    a_cross_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && crosses) |-> (!param_first[PARAM_W-1] && !param_second[PARAM_W-1]))
        else $error("crossing reported with negative parameter");
`endif

endmodule
